/* rtl/tssm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssm_pkg
// Shared types, codes and helpers of the transfer step statistics monitor.
// ----------------------------------------------------------------------------
package tssm_pkg;

  // Field widths fixed by the item formats.
  localparam int OP_W      = 3;
  localparam int HANDLE_W  = 5;
  localparam int CHAN_W    = 8;
  localparam int PID_W     = 22;
  localparam int TS_W      = 64;
  localparam int BYTES_W   = 32;
  localparam int SEL_W     = 3;
  localparam int CTR_W     = 64;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 22;

  // Default pool and channel sizes.
  localparam int DEF_OP_SLOTS   = 16;
  localparam int DEF_STEP_SLOTS = 32;
  localparam int DEF_CHANNELS   = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_PID = 1'd1;

  // Event codes.
  typedef enum logic [OP_W-1:0] {
    OP_START_OP     = 3'd0,
    OP_START_STEP   = 3'd1,
    OP_ADD_BYTES    = 3'd2,
    OP_STOP_OP      = 3'd3,
    OP_STOP_STEP    = 3'd4,
    OP_READ_COUNTER = 3'd5
  } op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } state_e;

  // Input item.
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle;
    logic                handle_present;
    logic [CHAN_W-1:0]   channel;
    logic                is_send;
    logic [PID_W-1:0]    event_process_id;
    logic [TS_W-1:0]     timestamp_ns;
    logic [BYTES_W-1:0]  byte_count;
    logic [SEL_W-1:0]    counter_select;
  } req_t;

  // Result item.
  typedef struct packed {
    logic [HANDLE_W-1:0] issued_handle;
    logic                issued_valid;
    logic [CTR_W-1:0]    read_value;
  } rsp_t;

  // One channel-direction row of the counter memory.
  typedef struct packed {
    logic [CTR_W-1:0] dur_max;
    logic [CTR_W-1:0] dur_sum;
    logic [CTR_W-1:0] byte_sum;
    logic [CTR_W-1:0] cnt;
  } ctr_row_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clear_en;
    logic lookup_fin;
    logic update_fin;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic needs_update;
    logic out_free;
  } stat_t;

  // Lowest set bit of a map, with a found flag in the top bit.
  function automatic logic [HANDLE_W:0] lowest_set(input logic [31:0] map);
    logic [HANDLE_W:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (map[i]) begin
        r = {1'b1, HANDLE_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

/* rtl/tssm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tssm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tssm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssm_ctrl
// Sequencer: counter clearing after reset, item accept, lookup and update.
// ----------------------------------------------------------------------------
module tssm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  tssm_pkg::stat_t stat,
  output tssm_pkg::cmd_t  cmd
);
  import tssm_pkg::*;

  state_e state;
  state_e state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // A counting stop goes on to the update state, where the duration is ready.
        if (stat.needs_update) begin
          state_next = ST_UPDATE;
        end else if (stat.out_free) begin
          cmd.lookup_fin = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_UPDATE: begin
        if (stat.out_free) begin
          cmd.update_fin = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/tssm_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssm_dp
// Datapath: handle pools, slot stores, step memories, counter memory and
// the result register.
// ----------------------------------------------------------------------------
module tssm_dp #(
  parameter int OP_SLOTS   = tssm_pkg::DEF_OP_SLOTS,
  parameter int STEP_SLOTS = tssm_pkg::DEF_STEP_SLOTS,
  parameter int CHANNELS   = tssm_pkg::DEF_CHANNELS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tssm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tssm_pkg::CFG_W-1:0]     cfg_data,
  input  tssm_pkg::req_t                 req,
  input  tssm_pkg::cmd_t                 cmd,
  output tssm_pkg::stat_t                stat,
  input  logic                           rsp_stall,
  output logic                           rsp_valid,
  output tssm_pkg::rsp_t                 rsp
);
  import tssm_pkg::*;

  localparam int OP_IW   = (OP_SLOTS > 1) ? $clog2(OP_SLOTS) : 1;
  localparam int STEP_IW = (STEP_SLOTS > 1) ? $clog2(STEP_SLOTS) : 1;
  localparam int CH_IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ROWS    = 2 * CHANNELS;
  localparam int ROW_AW  = $clog2(ROWS);
  localparam logic [HANDLE_W:0] OP_LIM   = OP_SLOTS[HANDLE_W:0];
  localparam logic [HANDLE_W:0] STEP_LIM = STEP_SLOTS[HANDLE_W:0];
  localparam logic [CHAN_W:0]   CH_LIM   = CHANNELS[CHAN_W:0];
  localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);

  // Configuration registers.
  logic             enable;
  logic [PID_W-1:0] own_pid;

  // Pools and slot stores.
  logic [OP_SLOTS-1:0]   op_free;
  logic [STEP_SLOTS-1:0] step_free;
  logic [CHAN_W-1:0]     op_chan     [OP_SLOTS];
  logic                  op_dir      [OP_SLOTS];
  logic [OP_IW-1:0]      step_parent [STEP_SLOTS];

  // Item held for the lookup and update cycles.
  req_t              item;
  logic [ROW_AW-1:0] row;
  logic              chan_ok;
  logic              upd;
  logic [CTR_W-1:0]  dur;
  logic [ROW_AW-1:0] clear_idx;

  // Request-side decode for the memory addresses.
  logic [STEP_IW-1:0] req_step_idx;
  logic [OP_IW-1:0]   req_parent;
  logic [CHAN_W-1:0]  req_chan;
  logic               req_row_bit;
  logic               req_step_ok;
  logic [ROW_AW-1:0]  row_next;
  logic               chan_ok_next;
  logic               upd_next;

  // Lookup-side decode.
  logic [STEP_IW-1:0] it_step_idx;
  logic [OP_IW-1:0]   it_op_idx;
  logic               it_op_ok;
  logic               it_step_ok;
  logic               it_alloc;
  logic [HANDLE_W:0]  op_pick;
  logic [HANDLE_W:0]  step_pick;
  logic [OP_IW-1:0]   op_slot;
  logic [STEP_IW-1:0] step_slot;
  logic               start_op_ok;
  logic               start_step_ok;
  logic               add_ok;
  logic               stop_op_ok;
  logic               stop_step_ok;
  rsp_t               result;

  // Memory ports.
  logic [TS_W-1:0]    start_rd;
  logic [CTR_W-1:0]   total_rd;
  logic [STEP_IW-1:0] step_raddr;
  logic               total_we;
  logic [STEP_IW-1:0] total_waddr;
  logic [CTR_W-1:0]   total_wdata;
  ctr_row_t           ctr_rd;
  ctr_row_t           ctr_upd;
  ctr_row_t           ctr_wdata;
  logic [ROW_AW-1:0]  ctr_waddr;
  logic [ROW_AW-1:0]  ctr_raddr;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable  <= 1'b0;
      own_pid <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:  enable  <= cfg_data[0];
        CFG_OWN_PID: own_pid <= cfg_data[PID_W-1:0];
        default:     ;
      endcase
    end
  end

  // Counter row for the incoming item: parent channel of a stop, or the
  // channel and direction named by a counter read.
  always_comb begin
    req_step_idx = req.handle[STEP_IW-1:0];
    req_step_ok  = {1'b0, req.handle} < STEP_LIM;
    req_parent   = step_parent[req_step_idx];
    if (req.op == OP_READ_COUNTER) begin
      req_chan    = req.channel;
      req_row_bit = req.counter_select[SEL_W-1];
    end else begin
      req_chan    = op_chan[req_parent];
      req_row_bit = ~op_dir[req_parent];
    end
    row_next     = ROW_AW'({req_chan[CH_IW-1:0], req_row_bit});
    chan_ok_next = {1'b0, req_chan} < CH_LIM;
    upd_next     = (req.op == OP_STOP_STEP) && req.handle_present && req_step_ok &&
                   !step_free[req_step_idx] && enable && chan_ok_next;
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item    <= req;
      row     <= row_next;
      chan_ok <= chan_ok_next;
      upd     <= upd_next;
    end
  end

  // Duration of a stopping step.
  always_ff @(posedge clk) begin
    dur <= item.timestamp_ns - start_rd;
  end

  // Event decode on the held item.
  always_comb begin
    it_step_idx   = item.handle[STEP_IW-1:0];
    it_op_idx     = item.handle[OP_IW-1:0];
    it_op_ok      = {1'b0, item.handle} < OP_LIM;
    it_step_ok    = {1'b0, item.handle} < STEP_LIM;
    it_alloc      = !step_free[it_step_idx];
    op_pick       = lowest_set(32'(op_free));
    step_pick     = lowest_set(32'(step_free));
    op_slot       = op_pick[OP_IW-1:0];
    step_slot     = step_pick[STEP_IW-1:0];
    start_op_ok   = (item.op == OP_START_OP) && enable &&
                    (item.event_process_id == own_pid) && op_pick[HANDLE_W];
    start_step_ok = (item.op == OP_START_STEP) && enable && item.handle_present &&
                    it_op_ok && step_pick[HANDLE_W];
    add_ok        = (item.op == OP_ADD_BYTES) && item.handle_present &&
                    it_step_ok && it_alloc;
    stop_op_ok    = (item.op == OP_STOP_OP) && item.handle_present && it_op_ok;
    stop_step_ok  = (item.op == OP_STOP_STEP) && item.handle_present &&
                    it_step_ok && it_alloc;
  end

  // Result of the held item.
  always_comb begin
    result = '0;
    if (start_op_ok) begin
      result.issued_handle = op_pick[HANDLE_W-1:0];
      result.issued_valid  = 1'b1;
    end else if (start_step_ok) begin
      result.issued_handle = step_pick[HANDLE_W-1:0];
      result.issued_valid  = 1'b1;
    end else if ((item.op == OP_READ_COUNTER) && chan_ok) begin
      case (item.counter_select[1:0])
        2'd0:    result.read_value = ctr_rd.cnt;
        2'd1:    result.read_value = ctr_rd.byte_sum;
        2'd2:    result.read_value = ctr_rd.dur_sum;
        default: result.read_value = ctr_rd.dur_max;
      endcase
    end
  end

  // Pool bitmaps.
  always_ff @(posedge clk) begin
    if (rst) begin
      op_free   <= '1;
      step_free <= '1;
    end else if (cmd.lookup_fin) begin
      if (start_op_ok) begin
        op_free[op_slot] <= 1'b0;
      end
      if (stop_op_ok) begin
        op_free[it_op_idx] <= 1'b1;
      end
      if (start_step_ok) begin
        step_free[step_slot] <= 1'b0;
      end
      if (stop_step_ok) begin
        step_free[it_step_idx] <= 1'b1;
      end
    end else if (cmd.update_fin) begin
      step_free[it_step_idx] <= 1'b1;
    end
  end

  // Slot stores, written when a handle is issued.
  always_ff @(posedge clk) begin
    if (cmd.lookup_fin && start_op_ok) begin
      op_chan[op_slot] <= item.channel;
      op_dir[op_slot]  <= item.is_send;
    end
    if (cmd.lookup_fin && start_step_ok) begin
      step_parent[step_slot] <= item.handle[OP_IW-1:0];
    end
  end

  // Step start times and byte totals.
  assign step_raddr  = cmd.load ? req_step_idx : it_step_idx;
  assign total_we    = cmd.lookup_fin && (start_step_ok || add_ok);
  assign total_waddr = start_step_ok ? step_slot : it_step_idx;
  assign total_wdata = start_step_ok ? '0 : total_rd + CTR_W'(item.byte_count);

  tssm_ram #(
    .WIDTH (TS_W),
    .DEPTH (STEP_SLOTS)
  ) u_start_ram (
    .clk   (clk),
    .we    (cmd.lookup_fin && start_step_ok),
    .waddr (step_slot),
    .wdata (item.timestamp_ns),
    .raddr (step_raddr),
    .rdata (start_rd)
  );

  tssm_ram #(
    .WIDTH (CTR_W),
    .DEPTH (STEP_SLOTS)
  ) u_total_ram (
    .clk   (clk),
    .we    (total_we),
    .waddr (total_waddr),
    .wdata (total_wdata),
    .raddr (step_raddr),
    .rdata (total_rd)
  );

  // Counter row update for a counting stop.
  always_comb begin
    ctr_upd.cnt      = ctr_rd.cnt + CTR_W'(1);
    ctr_upd.byte_sum = ctr_rd.byte_sum + total_rd;
    ctr_upd.dur_sum  = ctr_rd.dur_sum + dur;
    ctr_upd.dur_max  = (dur > ctr_rd.dur_max) ? dur : ctr_rd.dur_max;
  end

  assign ctr_wdata = cmd.clear_en ? '0 : ctr_upd;
  assign ctr_waddr = cmd.clear_en ? clear_idx : row;
  assign ctr_raddr = cmd.load ? row_next : row;

  tssm_ram #(
    .WIDTH ($bits(ctr_row_t)),
    .DEPTH (ROWS)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (cmd.clear_en || cmd.update_fin),
    .waddr (ctr_waddr),
    .wdata (ctr_wdata),
    .raddr (ctr_raddr),
    .rdata (ctr_rd)
  );

  // Clearing pass over the counter rows after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_idx <= '0;
    end else if (cmd.clear_en) begin
      clear_idx <= clear_idx + ROW_AW'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.lookup_fin || cmd.update_fin) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup_fin || cmd.update_fin) begin
      rsp <= result;
    end
  end

  // Status to the controller.
  assign stat.clear_last   = (clear_idx == ROW_LAST);
  assign stat.needs_update = upd;
  assign stat.out_free     = !rsp_valid || !rsp_stall;

endmodule

/* rtl/transfer_step_stats_monitor_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transfer_step_stats_monitor_top
// Per-channel transfer statistics monitor with operation and step handle
// pools and 64-bit send and receive counters per channel.
// ----------------------------------------------------------------------------
// One item is taken at a time. Most items pass through an accept cycle,
// which presents the slot and counter memory addresses, and a lookup cycle,
// held while a stalled result fills the output register, that uses the
// registered read data and writes the result register. A counting stop_step
// also passes an update state: the duration is registered during the lookup
// and the four counters of the channel-direction row are written back in the
// update state. After reset the counter memory is cleared one row a cycle,
// all 2*CHANNELS rows (64 at the default size), with req_stall high;
// configuration writes are taken during that pass. A finished result waits
// in an output register and does not hold up the next accept.
module transfer_step_stats_monitor_top #(
  parameter int OP_SLOTS   = tssm_pkg::DEF_OP_SLOTS,
  parameter int STEP_SLOTS = tssm_pkg::DEF_STEP_SLOTS,
  parameter int CHANNELS   = tssm_pkg::DEF_CHANNELS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tssm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tssm_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  tssm_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output tssm_pkg::rsp_t                 rsp
);
  import tssm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  tssm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath.
  tssm_dp #(
    .OP_SLOTS   (OP_SLOTS),
    .STEP_SLOTS (STEP_SLOTS),
    .CHANNELS   (CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

/* rtl/tssm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssm_checker
// Port-level checks of the statistics monitor, bound to the top level.
// ----------------------------------------------------------------------------
module tssm_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input tssm_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input tssm_pkg::rsp_t rsp
);
  import tssm_pkg::*;

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // The block is busy in the cycle after it takes an item.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("item taken while the previous one is in work");

  // A new result only appears out of a busy cycle.
  assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result appeared without an item in work");

  // An issued handle and a counter read never share one result.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.issued_valid |-> rsp.read_value == '0)
    else $error("issued handle with a nonzero read value");

endmodule

bind transfer_step_stats_monitor_top tssm_checker u_tssm_checker (.*);

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the transfer step statistics monitor. A queue of
// pending items feeds a clocked driver, which predicts each result at the
// moment its item is accepted. A clocked checker compares every result with
// the oldest prediction. Directed corner items come first, then phases of
// random operation and step traffic under several register settings and
// idle patterns.
// ----------------------------------------------------------------------------
module tb;
  import tssm_pkg::*;

  localparam int OP_SLOTS   = DEF_OP_SLOTS;
  localparam int STEP_SLOTS = DEF_STEP_SLOTS;
  localparam int CHANNELS   = DEF_CHANNELS;
  localparam int OP_IDX_W   = $clog2(OP_SLOTS);

  // Counter row layout: four counters per direction, send first.
  localparam int CNT_ROW       = 8;
  localparam int CNT_SEND_BASE = 0;
  localparam int CNT_RECV_BASE = 4;
  localparam int CNT_COUNT     = 0;
  localparam int CNT_BYTES     = 1;
  localparam int CNT_DUR       = 2;
  localparam int CNT_MAX       = 3;

  // Event codes that the block must ignore.
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  localparam logic [PID_W-1:0] PID_MAX = '1;
  localparam logic [TS_W-1:0]  TS_MAX  = '1;

  localparam int SETTLE_CYCLES = 4;
  localparam int END_SETTLE    = 16;
  localparam int HOLD_AT       = 150;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;

  typedef enum logic [1:0] {
    ENT_ITEM,
    ENT_CFG,
    ENT_DRAIN
  } stim_kind_e;

  typedef struct packed {
    stim_kind_e             kind;
    req_t                   item;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_W-1:0]       data;
  } stim_entry_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp;

  // Stimulus and expectation stores.
  stim_entry_t pending_items[$];
  rsp_t        expected_rsp[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int drain_wait = 0;
  int results_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  logic [TS_W-1:0] ts_now = 64'hFFFF_FFFF_FFF8_0000;

  // Shadow of the block's registers and state.
  logic                cfg_enable = 1'b0;
  logic [PID_W-1:0]    cfg_pid = '0;
  logic [OP_SLOTS-1:0]   op_free = '1;
  logic [OP_SLOTS-1:0]   op_written = '0;
  logic [STEP_SLOTS-1:0] step_free = '1;
  logic [CHAN_W-1:0]   op_chan [OP_SLOTS] = '{default: '0};
  logic                op_dir [OP_SLOTS] = '{default: '0};
  logic [OP_IDX_W-1:0] step_parent [STEP_SLOTS] = '{default: '0};
  logic [TS_W-1:0]     step_t0 [STEP_SLOTS] = '{default: '0};
  logic [CTR_W-1:0]    step_bytes [STEP_SLOTS] = '{default: '0};
  logic [CTR_W-1:0]    chan_counters [CHANNELS*CNT_ROW] = '{default: '0};

  transfer_step_stats_monitor_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Lowest free slot among the first n bits, or -1 when the pool is full.
  function automatic int lowest_free_slot(input logic [31:0] map, input int n);
    for (int i = 0; i < n; i++) begin
      if (map[i]) begin
        return i;
      end
    end
    return -1;
  endfunction

  // A random set bit of a map, or -1 when none is set.
  function automatic int pick_set(input logic [31:0] map);
    int n;
    int k;
    n = $countones(map);
    if (n == 0) begin
      return -1;
    end
    k = $urandom_range(n - 1, 0);
    for (int i = 0; i < 32; i++) begin
      if (map[i]) begin
        if (k == 0) begin
          return i;
        end
        k--;
      end
    end
    return -1;
  endfunction

  // Mostly rising time with small steps; now and then an arbitrary value.
  function automatic logic [TS_W-1:0] next_timestamp();
    if ($urandom_range(9, 0) == 0) begin
      return {$urandom, $urandom};
    end
    ts_now = ts_now + $urandom_range(5000, 1);
    return ts_now;
  endfunction

  // Applies one accepted item to the shadow state and returns its result.
  function automatic rsp_t event_response(input req_t r);
    rsp_t                o;
    int                  slot;
    logic [OP_IDX_W-1:0] parent;
    logic [CHAN_W-1:0]   pch;
    int                  base;
    logic [CTR_W-1:0]    dur;
    o = '0;
    case (r.op)
      OP_START_OP: begin
        if (cfg_enable && r.event_process_id == cfg_pid) begin
          slot = lowest_free_slot(op_free, OP_SLOTS);
          if (slot >= 0) begin
            op_free[slot] = 1'b0;
            op_written[slot] = 1'b1;
            op_chan[slot] = r.channel;
            op_dir[slot] = r.is_send;
            o.issued_handle = HANDLE_W'(slot);
            o.issued_valid = 1'b1;
          end
        end
      end
      OP_START_STEP: begin
        if (cfg_enable && r.handle_present && r.handle < OP_SLOTS) begin
          slot = lowest_free_slot(step_free, STEP_SLOTS);
          if (slot >= 0) begin
            step_free[slot] = 1'b0;
            step_parent[slot] = OP_IDX_W'(r.handle);
            step_t0[slot] = r.timestamp_ns;
            step_bytes[slot] = '0;
            o.issued_handle = HANDLE_W'(slot);
            o.issued_valid = 1'b1;
          end
        end
      end
      OP_ADD_BYTES: begin
        if (r.handle_present && r.handle < STEP_SLOTS && !step_free[r.handle]) begin
          step_bytes[r.handle] = step_bytes[r.handle] + CTR_W'(r.byte_count);
        end
      end
      OP_STOP_OP: begin
        if (r.handle_present && r.handle < OP_SLOTS) begin
          op_free[r.handle] = 1'b1;
        end
      end
      OP_STOP_STEP: begin
        if (r.handle_present && r.handle < STEP_SLOTS && !step_free[r.handle]) begin
          parent = step_parent[r.handle];
          pch = op_chan[parent];
          if (cfg_enable && pch < CHANNELS) begin
            base = int'(pch) * CNT_ROW + (op_dir[parent] ? CNT_SEND_BASE : CNT_RECV_BASE);
            dur = r.timestamp_ns - step_t0[r.handle];
            chan_counters[base + CNT_COUNT] = chan_counters[base + CNT_COUNT] + 1;
            chan_counters[base + CNT_BYTES] =
              chan_counters[base + CNT_BYTES] + step_bytes[r.handle];
            chan_counters[base + CNT_DUR] = chan_counters[base + CNT_DUR] + dur;
            if (dur > chan_counters[base + CNT_MAX]) begin
              chan_counters[base + CNT_MAX] = dur;
            end
          end
          step_free[r.handle] = 1'b1;
        end
      end
      OP_READ_COUNTER: begin
        if (r.channel < CHANNELS) begin
          o.read_value = chan_counters[int'(r.channel) * CNT_ROW + int'(r.counter_select)];
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  // Random item. Most items follow live handles so that steps accumulate
  // and stop; the rest are left as raw noise.
  function automatic req_t random_event(input logic [PID_W-1:0] pid, input bit fill);
    logic [159:0]        raw;
    req_t                r;
    logic [OP_SLOTS-1:0] live_ops;
    logic [OP_SLOTS-1:0] busy_ops;
    logic [STEP_SLOTS-1:0] busy_steps;
    int                  w;
    int                  s;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    busy_ops = ~op_free;
    live_ops = busy_ops & op_written;
    busy_steps = ~step_free;
    w = $urandom_range(99, 0);
    if (w < (fill ? 16 : 12)) begin
      r.op = OP_START_OP;
    end else if (w < (fill ? 45 : 30)) begin
      r.op = OP_START_STEP;
    end else if (w < (fill ? 65 : 50)) begin
      r.op = OP_ADD_BYTES;
    end else if (w < (fill ? 67 : 58)) begin
      r.op = OP_STOP_OP;
    end else if (w < (fill ? 72 : 78)) begin
      r.op = OP_STOP_STEP;
    end else if (w < 95) begin
      r.op = OP_READ_COUNTER;
    end else begin
      r.op = w[0] ? OP_RSVD_6 : OP_RSVD_7;
    end
    if ($urandom_range(99, 0) >= 15) begin
      r.handle_present = 1'b1;
      case (r.op)
        OP_START_OP: begin
          r.event_process_id = pid;
          if ($urandom_range(4, 0) != 0) begin
            r.channel = $urandom_range(CHANNELS - 1, 0);
          end
        end
        OP_START_STEP: begin
          s = pick_set(live_ops);
          if (s < 0) begin
            s = pick_set(op_written);
          end
          if (s >= 0) begin
            r.handle = HANDLE_W'(s);
          end
          r.timestamp_ns = next_timestamp();
        end
        OP_ADD_BYTES: begin
          s = pick_set(busy_steps);
          if (s >= 0) begin
            r.handle = HANDLE_W'(s);
          end
          if (r.byte_count[0]) begin
            r.byte_count = $urandom_range(4095, 0);
          end
        end
        OP_STOP_OP: begin
          s = pick_set(busy_ops);
          if (s >= 0) begin
            r.handle = HANDLE_W'(s);
          end
        end
        OP_STOP_STEP: begin
          s = pick_set(busy_steps);
          if (s >= 0) begin
            r.handle = HANDLE_W'(s);
          end
          r.timestamp_ns = next_timestamp();
        end
        OP_READ_COUNTER: begin
          if ($urandom_range(6, 0) != 0) begin
            r.channel = $urandom_range(CHANNELS - 1, 0);
          end
        end
        default: begin
        end
      endcase
    end
    // A step may only name an operation slot whose channel has been recorded.
    if (r.op == OP_START_STEP && r.handle_present && r.handle < OP_SLOTS &&
        !op_written[r.handle[OP_IDX_W-1:0]]) begin
      s = pick_set(op_written);
      if (s >= 0) begin
        r.handle = HANDLE_W'(s);
      end else begin
        r.handle = r.handle | HANDLE_W'(OP_SLOTS);
      end
    end
    return r;
  endfunction

  function automatic req_t make_event(input logic [OP_W-1:0] op, input int h,
                                      input bit present, input int ch, input bit snd,
                                      input logic [PID_W-1:0] pid,
                                      input logic [TS_W-1:0] ts,
                                      input logic [BYTES_W-1:0] nbytes, input int sel);
    req_t r;
    r.op = op;
    r.handle = HANDLE_W'(h);
    r.handle_present = present;
    r.channel = CHAN_W'(ch);
    r.is_send = snd;
    r.event_process_id = pid;
    r.timestamp_ns = ts;
    r.byte_count = nbytes;
    r.counter_select = SEL_W'(sel);
    return r;
  endfunction

  // Keeps the pending queue short so that items follow the live state.
  task automatic enqueue(input stim_entry_t e);
    while (pending_items.size() >= 2) begin
      @(negedge clk);
    end
    pending_items.push_back(e);
  endtask

  task automatic push_item(input req_t r);
    stim_entry_t e;
    e = '0;
    e.kind = ENT_ITEM;
    e.item = r;
    enqueue(e);
  endtask

  // Waits for the block to drain, then writes both registers.
  task automatic configure(input logic en, input logic [PID_W-1:0] pid);
    stim_entry_t e;
    e = '0;
    e.kind = ENT_DRAIN;
    enqueue(e);
    e.kind = ENT_CFG;
    e.index = CFG_ENABLE;
    e.data = CFG_W'(en);
    enqueue(e);
    e.index = CFG_OWN_PID;
    e.data = pid;
    enqueue(e);
  endtask

  // Driver: presents items, writes registers and predicts each accepted item.
  always @(posedge clk) begin : item_driver
    logic        took;
    logic        holding;
    logic        issue;
    logic        write_cfg;
    stim_entry_t head;
    took = req_valid && !req_stall;
    holding = req_valid && !took;
    issue = 1'b0;
    write_cfg = 1'b0;
    head = '0;
    if (!rst) begin
      if (took) begin
        expected_rsp.push_back(event_response(req));
      end
      if (!holding && pending_items.size() != 0) begin
        head = pending_items[0];
        case (head.kind)
          ENT_DRAIN: begin
            if (expected_rsp.size() != 0) begin
              drain_wait = 0;
            end else if (drain_wait == SETTLE_CYCLES) begin
              drain_wait = 0;
              void'(pending_items.pop_front());
            end else begin
              drain_wait++;
            end
          end
          ENT_CFG: begin
            write_cfg = 1'b1;
            if (head.index == CFG_ENABLE) begin
              cfg_enable = head.data[0];
            end else begin
              cfg_pid = head.data;
            end
            void'(pending_items.pop_front());
          end
          default: begin
            if ($urandom_range(99, 0) >= send_idle_pct) begin
              issue = 1'b1;
              void'(pending_items.pop_front());
            end
          end
        endcase
      end
      if (!holding) begin
        req_valid <= issue;
      end
      if (issue) begin
        req <= head.item;
      end
      cfg_we <= write_cfg;
      if (write_cfg) begin
        cfg_index <= head.index;
        cfg_data <= head.data;
      end
    end
  end

  // Checker: compares each result with the oldest prediction and drives stall.
  always @(posedge clk) begin : result_checker
    rsp_t want;
    logic next_stall;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (results_seen == HOLD_AT) begin
          hold_left = HOLD_CYCLES;
        end
        if (expected_rsp.size() == 0) begin
          fail_count++;
          $error("result with no item outstanding: handle %0d valid %0d value %0h",
                 rsp.issued_handle, rsp.issued_valid, rsp.read_value);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.issued_handle !== want.issued_handle) begin
            fail_count++;
            $error("issued_handle: expected %0d, got %0d",
                   want.issued_handle, rsp.issued_handle);
          end
          if (rsp.issued_valid !== want.issued_valid) begin
            fail_count++;
            $error("issued_valid: expected %0d, got %0d", want.issued_valid, rsp.issued_valid);
          end
          if (rsp.read_value !== want.read_value) begin
            fail_count++;
            $error("read_value: expected %0h, got %0h", want.read_value, rsp.read_value);
          end
        end
      end
      // A long hold-off lets the block fill up and stall its input.
      if (hold_left != 0) begin
        next_stall = 1'b1;
        hold_left--;
      end else begin
        next_stall = $urandom_range(99, 0) < recv_stall_pct;
      end
      rsp_stall <= next_stall;
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin : watchdog
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic             en;
    logic [PID_W-1:0] pid;
    int               n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: the block is disabled and only ignores or reads.
    push_item(make_event(OP_START_OP, 0, 1, 0, 1, '0, '0, '0, 0));
    push_item(make_event(OP_START_STEP, 16, 1, 0, 0, '0, '0, '0, 0));
    push_item(make_event(OP_RSVD_6, 31, 1, 255, 1, PID_MAX, TS_MAX, '1, 7));
    push_item(make_event(OP_RSVD_7, 31, 1, 255, 1, PID_MAX, TS_MAX, '1, 7));
    push_item(make_event(OP_READ_COUNTER, 0, 0, 0, 0, '0, '0, '0, 0));

    configure(1'b1, PID_MAX);
    // Foreign process, then three operations including one on a channel
    // beyond the counter store.
    push_item(make_event(OP_START_OP, 0, 1, 0, 1, '0, '0, '0, 0));
    push_item(make_event(OP_START_OP, 0, 1, 0, 1, PID_MAX, '0, '0, 0));
    push_item(make_event(OP_START_OP, 0, 1, 31, 0, PID_MAX, '0, '0, 0));
    push_item(make_event(OP_START_OP, 0, 1, 255, 1, PID_MAX, '0, '0, 0));
    // Step on the first operation; null and out-of-range parents are ignored.
    push_item(make_event(OP_START_STEP, 0, 1, 0, 0, '0, '0, '0, 0));
    push_item(make_event(OP_START_STEP, 0, 0, 0, 0, '0, '0, '0, 0));
    push_item(make_event(OP_START_STEP, 20, 1, 0, 0, '0, '0, '0, 0));
    // Byte totals grow past 32 bits; a free step slot takes no bytes.
    push_item(make_event(OP_ADD_BYTES, 0, 1, 0, 0, '0, '0, '1, 0));
    push_item(make_event(OP_ADD_BYTES, 0, 1, 0, 0, '0, '0, '1, 0));
    push_item(make_event(OP_ADD_BYTES, 5, 1, 0, 0, '0, '0, '1, 0));
    push_item(make_event(OP_ADD_BYTES, 0, 0, 0, 0, '0, '0, '1, 0));
    // Largest duration, then a second stop of the freed slot.
    push_item(make_event(OP_STOP_STEP, 0, 1, 0, 0, '0, TS_MAX, '0, 0));
    push_item(make_event(OP_STOP_STEP, 0, 1, 0, 0, '0, TS_MAX, '0, 0));
    // Stop before start wraps the duration; receive side of channel 31.
    push_item(make_event(OP_START_STEP, 1, 1, 0, 0, '0, 64'd100, '0, 0));
    push_item(make_event(OP_STOP_STEP, 0, 1, 0, 0, '0, 64'd50, '0, 0));
    // Parent channel beyond the store does not count.
    push_item(make_event(OP_START_STEP, 2, 1, 0, 0, '0, '0, '0, 0));
    push_item(make_event(OP_STOP_STEP, 0, 1, 0, 0, '0, 64'd10, '0, 0));
    push_item(make_event(OP_READ_COUNTER, 0, 0, 0, 0, '0, '0, '0, CNT_MAX));
    push_item(make_event(OP_READ_COUNTER, 0, 0, 31, 0, '0, '0, '0, CNT_RECV_BASE + CNT_DUR));
    push_item(make_event(OP_READ_COUNTER, 0, 0, 255, 0, '0, '0, '0, CNT_BYTES));
    push_item(make_event(OP_STOP_OP, 31, 1, 0, 0, '0, '0, '0, 0));
    push_item(make_event(OP_STOP_OP, 1, 0, 0, 0, '0, '0, '0, 0));
    push_item(make_event(OP_STOP_OP, 2, 1, 0, 0, '0, '0, '0, 0));

    // Random phases over register settings and idle patterns.
    for (int ph = 0; ph < 6; ph++) begin
      en = (ph != 2);
      pid = (ph == 0) ? PID_MAX : (ph == 1) ? '0 : PID_W'($urandom);
      n = (ph == 2) ? 150 : 280;
      configure(en, pid);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 49;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 49;
        end
        default: begin
          send_idle_pct = 9;
          recv_stall_pct = 9;
        end
      endcase
      for (int i = 0; i < n; i++) begin
        push_item(random_event(pid, ph[0] == 1'b0));
      end
    end

    while (pending_items.size() != 0 || req_valid || expected_rsp.size() != 0) begin
      @(negedge clk);
    end
    repeat (END_SETTLE) @(negedge clk);
    if (expected_rsp.size() != 0) begin
      fail_count++;
      $error("%0d results never arrived", expected_rsp.size());
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* transfer_step_stats_monitor_top.f */
rtl/tssm_pkg.sv
rtl/tssm_ram.sv
rtl/tssm_ctrl.sv
rtl/tssm_dp.sv
rtl/transfer_step_stats_monitor_top.sv
rtl/tssm_checker.sv
dv/tb.sv
